FILE: hw/rtl/swept_plane_collision_core_defines.svh
// ----------------------------------------------------------------------------
// swept_plane_collision_core_defines
// Assertion macros shared by the swept plane collision core.
// ----------------------------------------------------------------------------
`ifndef SWEPT_PLANE_COLLISION_CORE_DEFINES_SVH
`define SWEPT_PLANE_COLLISION_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SPC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Types, constants and helpers of the swept plane collision core.
// ----------------------------------------------------------------------------
package spc_pkg;

   typedef logic signed [31:0] word_type;

   localparam int        DIV_STEPS   = 17;
   localparam int        OFFSET_EPS  = 7;      // round(0.0001 * 2^16)
   localparam logic [16:0] REST_ONE  = 17'd65536;
   localparam int        LINK_IDX_W  = 6;
   localparam int        CNT_W       = 7;

   localparam logic [1:0] REG_PLANES_ENABLED = 2'd0;
   localparam logic [1:0] REG_PLANE_COUNT    = 2'd1;
   localparam logic [1:0] REG_DIE_ON_HIT     = 2'd2;

   localparam logic CMD_WRITE_PLANE   = 1'b0;
   localparam logic CMD_MOVE_PARTICLE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_DIV, ST_SCAN,
      ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_DONE
   } spc_state_type;

   typedef struct packed {
      logic             wr;
      logic [2:0]       slot;
      logic             mul;
      logic             sum;
      logic             div;
      logic             first;
      logic             scan;
      logic             enabled;
      logic [CNT_W-1:0] count;
   } spc_cell_ctl_type;

   typedef struct packed {
      logic                  hit;
      logic [16:0]           t;
      logic [LINK_IDX_W-1:0] idx;
      logic [2:0][15:0]      n;
      logic [16:0]           rest;
   } spc_link_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/swept_plane_collision_core.sv
// ----------------------------------------------------------------------------
// swept_plane_collision_core
// Swept particle against plane table test with reflection, one item at a time.
// ----------------------------------------------------------------------------
// Input stream req_*: tuser = {plane_slot, cmd}; cmd 0 stores a plane, cmd 1
// moves a particle. Output stream rsp_*: one transfer per input transfer,
// all zero for plane writes. Registers go over the csr_* APB port.
// Every plane owns a cell with its own distance multipliers and a 17-step
// restoring divider for the crossing time; the best hit then ripples down
// the row of cells, one cell a cycle, and a five-stage tail forms the hit
// point and the reflected velocity.
// A particle passes the multiply, sum, divider, ripple and tail states before
// its result is loaded; a plane write goes straight to its result. One item
// is in work at a time: a new item is taken only in the idle state, once the
// last result has gone to the output register.
// A finished result sits in the output register; the next item is taken
// while it waits, and only the final stage holds while rsp_tready is low.
// Reset clears the configuration registers, the sequencer, the output valid
// and the cell hit flags; the plane table holds garbage until each entry is written.
// ----------------------------------------------------------------------------
`include "swept_plane_collision_core_defines.svh"

module swept_plane_collision_core #(
   parameter int MAX_PLANES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, bounce, zero pad
   input  logic [311:0] req_tdata,
   // cmd, plane_slot
   input  logic [3:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z
   output logic [191:0] rsp_tdata,
   // hit, kill, hit_plane
   output logic [4:0]   rsp_tuser,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int CW = spc_pkg::CNT_W;

   spc_pkg::spc_state_type state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   en_ff, die_ff;
   logic [3:0]             count_ff;
   logic                   is_wr_ff;
   logic                   accept;
   logic                   out_load;
   spc_pkg::spc_cell_ctl_type ctl;

   spc_pkg::word_type  a_ff [3];
   spc_pkg::word_type  b_ff [3];
   spc_pkg::word_type  c_ff [3];
   spc_pkg::word_type  wp [3];
   logic signed [15:0] wn [3];

   spc_pkg::spc_link_type link_w [MAX_PLANES+1];
   spc_pkg::spc_link_type lk;

   logic signed [32:0] dab [3];
   logic signed [50:0] dpos_ff [3];
   logic signed [47:0] vnp_ff [3];
   logic signed [35:0] hp [3];
   logic signed [19:0] nmul [3];
   logic signed [19:0] off [3];
   logic signed [49:0] vn;
   logic signed [31:0] pos_ff [3];
   logic signed [42:0] vs_ff;
   logic               vneg_ff;
   logic signed [58:0] vsn_ff [3];
   logic signed [40:0] rv_ff [3];
   logic signed [58:0] rr_ff [3];

   logic               hit;
   logic [191:0]       res_data;
   logic [4:0]         res_user;
   logic               rsp_valid_ff;
   logic [191:0]       rsp_data_ff;
   logic [4:0]         rsp_user_ff;

   // configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff    <= 1'b0;
         count_ff <= '0;
         die_ff   <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            spc_pkg::REG_PLANES_ENABLED: en_ff    <= csr_pwdata[0];
            spc_pkg::REG_PLANE_COUNT:    count_ff <= csr_pwdata[3:0];
            spc_pkg::REG_DIE_ON_HIT:     die_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         spc_pkg::REG_PLANES_ENABLED: csr_prdata = {31'b0, en_ff};
         spc_pkg::REG_PLANE_COUNT:    csr_prdata = {28'b0, count_ff};
         spc_pkg::REG_DIE_ON_HIT:     csr_prdata = {31'b0, die_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // sequencer
   assign accept   = req_tvalid && req_tready;
   assign out_load = (state_ff == spc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_tuser[0] == spc_pkg::CMD_WRITE_PLANE) ?
                          spc_pkg::ST_DONE : spc_pkg::ST_MUL;
            end
         end
         spc_pkg::ST_MUL: state_in = spc_pkg::ST_SUM;
         spc_pkg::ST_SUM: state_in = spc_pkg::ST_DIV;
         spc_pkg::ST_DIV: begin
            if (cnt_ff == CW'(spc_pkg::DIV_STEPS - 1)) state_in = spc_pkg::ST_SCAN;
         end
         spc_pkg::ST_SCAN: begin
            if (cnt_ff == CW'(MAX_PLANES - 1)) state_in = spc_pkg::ST_F1;
         end
         spc_pkg::ST_F1: state_in = spc_pkg::ST_F2;
         spc_pkg::ST_F2: state_in = spc_pkg::ST_F3;
         spc_pkg::ST_F3: state_in = spc_pkg::ST_F4;
         spc_pkg::ST_F4: state_in = spc_pkg::ST_F5;
         spc_pkg::ST_F5: state_in = spc_pkg::ST_DONE;
         spc_pkg::ST_DONE: begin
            if (out_load) state_in = spc_pkg::ST_IDLE;
         end
         default: state_in = spc_pkg::ST_IDLE;
      endcase
      cnt_in = (state_in == state_ff) ? cnt_ff + CW'(1) : '0;
   end

   always_comb begin
      req_tready  = (state_ff == spc_pkg::ST_IDLE);
      ctl.wr      = accept && (req_tuser[0] == spc_pkg::CMD_WRITE_PLANE);
      ctl.slot    = req_tuser[3:1];
      ctl.mul     = (state_ff == spc_pkg::ST_MUL);
      ctl.sum     = (state_ff == spc_pkg::ST_SUM);
      ctl.div     = (state_ff == spc_pkg::ST_DIV);
      ctl.first   = (cnt_ff == '0);
      ctl.scan    = (state_ff == spc_pkg::ST_SCAN);
      ctl.enabled = en_ff;
      ctl.count   = (CW'(count_ff) > CW'(MAX_PLANES)) ? CW'(MAX_PLANES) : CW'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spc_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         is_wr_ff <= (req_tuser[0] == spc_pkg::CMD_WRITE_PLANE);
         for (int k = 0; k < 3; k++) begin
            a_ff[k] <= req_tdata[32*k +: 32];
            b_ff[k] <= req_tdata[96 + 32*k +: 32];
            c_ff[k] <= req_tdata[192 + 32*k +: 32];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wp[k] = req_tdata[32*k +: 32];
         wn[k] = req_tdata[192 + 32*k +: 16];
      end
   end

   // row of plane cells
   assign link_w[0] = '0;

   for (genvar i = 0; i < MAX_PLANES; i++) begin : g_cell
      spc_cell #(.IDX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .pa       (a_ff),
         .pb       (b_ff),
         .wp       (wp),
         .wn       (wn),
         .wrest    (req_tdata[304:288]),
         .link_in  (link_w[i]),
         .link_out (link_w[i+1])
      );
   end

   assign lk = link_w[MAX_PLANES];

   // hit point and reflection tail
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dab[k]  = 33'(b_ff[k]) - 33'(a_ff[k]);
         hp[k]   = 36'(a_ff[k]) + 36'(dpos_ff[k] >>> 16);
         nmul[k] = 20'($signed(lk.n[k])) * 20'(spc_pkg::OFFSET_EPS);
         off[k]  = nmul[k] >>> 14;
      end
      vn = 50'(vnp_ff[0]) + 50'(vnp_ff[1]) + 50'(vnp_ff[2]);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         dpos_ff[k] <= 51'(dab[k]) * 51'($signed({1'b0, lk.t}));
         vnp_ff[k]  <= 48'(c_ff[k]) * 48'($signed(lk.n[k]));
         pos_ff[k]  <= spc_pkg::sat32(64'(hp[k]) + 64'(off[k]));
         vsn_ff[k]  <= 59'(vs_ff) * 59'($signed(lk.n[k]));
         rv_ff[k]   <= 41'(c_ff[k]) - 41'(vsn_ff[k] >>> 20);
         rr_ff[k]   <= 59'(rv_ff[k]) * 59'($signed({1'b0, lk.rest}));
      end
      vs_ff   <= 43'(vn >>> 7);
      vneg_ff <= vn[49];
   end

   always_comb begin
      hit = lk.hit && !is_wr_ff;
      for (int k = 0; k < 3; k++) begin
         if (is_wr_ff) begin
            res_data[32*k +: 32]      = '0;
            res_data[96 + 32*k +: 32] = '0;
         end else begin
            res_data[32*k +: 32] = hit ? pos_ff[k] : b_ff[k];
            res_data[96 + 32*k +: 32] = (hit && !die_ff && vneg_ff) ?
                                        spc_pkg::sat32(64'(rr_ff[k] >>> 16)) : c_ff[k];
         end
      end
      res_user = {hit ? lk.idx[2:0] : 3'b0, hit && die_ff, hit};
   end

   // output register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= res_data;
         rsp_user_ff <= res_user;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `SPC_ASSERT_NEXT(a_done_loads, out_load, rsp_tvalid && req_tready, "result not presented")
   `SPC_ASSERT_SAME(a_kill_hit, rsp_tvalid && rsp_tuser[1], rsp_tuser[0], "kill without hit")
   `SPC_ASSERT_SAME(a_idx_zero, rsp_tvalid && !rsp_tuser[0], rsp_tuser[4:2] == 3'b0, "index without hit")

endmodule

FILE: hw/rtl/spc_cell.sv
// ----------------------------------------------------------------------------
// spc_cell
// One plane of the table: distances, crossing time and best-hit link stage.
// ----------------------------------------------------------------------------
module spc_cell #(
   parameter int IDX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spc_pkg::spc_cell_ctl_type ctl,
   input  spc_pkg::word_type        pa [3],
   input  spc_pkg::word_type        pb [3],
   input  spc_pkg::word_type        wp [3],
   input  logic signed [15:0]       wn [3],
   input  logic [16:0]              wrest,
   input  spc_pkg::spc_link_type    link_in,
   output spc_pkg::spc_link_type    link_out
);

   logic signed [31:0] pt_ff [3];
   logic signed [15:0] nrm_ff [3];
   logic [16:0]        rst_ff;
   logic signed [32:0] da [3];
   logic signed [32:0] db [3];
   logic signed [48:0] pa_in [3];
   logic signed [48:0] pb_in [3];
   logic signed [48:0] pa_ff [3];
   logic signed [48:0] pb_ff [3];
   logic signed [50:0] dp_in;
   logic signed [50:0] dc_in;
   logic signed [51:0] den_in;
   logic signed [51:0] den_ff;
   logic               en;
   logic               cand_in;
   logic               cand_ff;
   logic [53:0]        dv;
   logic [53:0]        rs;
   logic               ge;
   logic [53:0]        r_in;
   logic [53:0]        r_ff;
   logic [16:0]        q_in;
   logic [16:0]        q_ff;
   logic [16:0]        t;
   logic               take;
   spc_pkg::spc_link_type own;
   spc_pkg::spc_link_type link_in_w;
   spc_pkg::spc_link_type link_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         da[k]    = 33'(pa[k]) - 33'(pt_ff[k]);
         db[k]    = 33'(pb[k]) - 33'(pt_ff[k]);
         pa_in[k] = 49'(da[k]) * 49'(nrm_ff[k]);
         pb_in[k] = 49'(db[k]) * 49'(nrm_ff[k]);
      end
      en      = ctl.enabled && (spc_pkg::CNT_W'(IDX) < ctl.count);
      dp_in   = 51'(pa_ff[0]) + 51'(pa_ff[1]) + 51'(pa_ff[2]);
      dc_in   = 51'(pb_ff[0]) + 51'(pb_ff[1]) + 51'(pb_ff[2]);
      den_in  = 52'(dp_in) - 52'(dc_in);
      cand_in = en && !dp_in[50] && (dc_in[50] || dc_in == '0);
      dv      = 54'($unsigned(den_ff));
      rs      = ctl.first ? r_ff : {r_ff[52:0], 1'b0};
      ge      = rs >= dv;
      r_in    = ge ? rs - dv : rs;
      q_in    = {q_ff[15:0], ge};
      t       = (den_ff == '0) ? '0 : q_ff;
      own.hit  = cand_ff;
      own.t    = t;
      own.idx  = spc_pkg::LINK_IDX_W'(IDX);
      own.n[0] = nrm_ff[0];
      own.n[1] = nrm_ff[1];
      own.n[2] = nrm_ff[2];
      own.rest = rst_ff;
      link_in_w = link_in;
      take      = cand_ff && (!link_in_w.hit || t < link_in_w.t);
   end

   always_ff @(posedge clock) begin
      if (ctl.wr && spc_pkg::CNT_W'(ctl.slot) == spc_pkg::CNT_W'(IDX)) begin
         pt_ff  <= wp;
         nrm_ff <= wn;
         rst_ff <= (wrest > spc_pkg::REST_ONE) ? spc_pkg::REST_ONE : wrest;
      end
      if (ctl.mul) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (ctl.sum) begin
         den_ff <= den_in;
         r_ff   <= 54'($unsigned(dp_in));
         q_ff   <= '0;
      end else if (ctl.div) begin
         r_ff <= r_in;
         q_ff <= q_in;
      end
      if (reset) begin
         cand_ff     <= 1'b0;
         link_ff.hit <= 1'b0;
      end else begin
         if (ctl.sum) begin
            cand_ff <= cand_in;
         end
         if (ctl.scan) begin
            link_ff <= take ? own : link_in_w;
         end
      end
   end

   assign link_out = link_ff;

endmodule
